[src/dspe_pkg.sv]
`default_nettype none

package dspe_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_OFS_UNIT = 2'd1;
    localparam logic [1:0] CFG_OFS_AMT  = 2'd2;

    // Format codes
    localparam logic [3:0] FMT_YEAR     = 4'd0;
    localparam logic [3:0] FMT_MONTH    = 4'd1;
    localparam logic [3:0] FMT_DAY      = 4'd2;
    localparam logic [3:0] FMT_HOUR     = 4'd3;
    localparam logic [3:0] FMT_MINUTE   = 4'd4;
    localparam logic [3:0] FMT_SECOND   = 4'd5;
    localparam logic [3:0] FMT_YM       = 4'd6;
    localparam logic [3:0] FMT_YYYYMMDD = 4'd7;
    localparam logic [3:0] FMT_MMDDYYYY = 4'd8;
    localparam logic [3:0] FMT_YMD      = 4'd9;

    // Offset units
    localparam logic [1:0] OFS_YEAR  = 2'd1;
    localparam logic [1:0] OFS_MONTH = 2'd2;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Month offset: floor(t/12) through a bias that keeps t non-negative
    localparam logic [17:0] DIV_BIAS = 18'd16391;  // 12*1366 - 1 (month is 1-based)
    localparam logic [15:0] Q_BIAS   = 16'd1366;
    localparam logic [15:0] RECIP3   = 16'd43691;  // ceil(2^17 / 3)
    localparam logic [15:0] RECIP10  = 16'd52429;  // ceil(2^19 / 10)

    // One parsed date string as it crosses the queue
    typedef struct packed {
        logic        err;
        logic [13:0] year;
        logic [6:0]  mon;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  mins;
        logic [6:0]  secs;
    } t_rec;

    typedef struct packed {
        logic [3:0]  fmt;
        logic [1:0]  ofs_unit;
        logic [14:0] amt;
    } t_cfg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OFFS,
        BK_DIV,
        BK_FIX,
        BK_ABS,
        BK_CONV,
        BK_EMIT
    } t_bk_state;

    typedef enum logic [2:0] {
        SEG_END,
        SEG_YEAR,
        SEG_DASH,
        SEG_FLD1,
        SEG_FLD2
    } t_seg;

    typedef enum logic [2:0] {
        FLD_MON,
        FLD_DAY,
        FLD_HOUR,
        FLD_MIN,
        FLD_SEC
    } t_fld;

    typedef struct packed {
        t_seg kind;
        t_fld fld;
    } t_seg_op;

    // Tens digit of a value below 128
    function automatic logic [3:0] dspe_tens(input logic [6:0] v);
        logic [14:0] p;
        p = {8'b0, v} * 15'd205;
        return p[14:11];
    endfunction

    // Output program: segment idx of the layout picked by fmt
    function automatic t_seg_op dspe_seg_op(input logic [3:0] fmt, input logic [2:0] idx);
        t_seg_op op;
        op.kind = SEG_END;
        op.fld  = FLD_MON;
        case (fmt)
            FMT_YEAR: begin
                if (idx == 3'd0) op.kind = SEG_YEAR;
            end
            FMT_MONTH: begin
                if (idx == 3'd0) op.kind = SEG_FLD1;
                op.fld = FLD_MON;
            end
            FMT_DAY: begin
                if (idx == 3'd0) op.kind = SEG_FLD1;
                op.fld = FLD_DAY;
            end
            FMT_HOUR: begin
                if (idx == 3'd0) op.kind = SEG_FLD1;
                op.fld = FLD_HOUR;
            end
            FMT_MINUTE: begin
                if (idx == 3'd0) op.kind = SEG_FLD1;
                op.fld = FLD_MIN;
            end
            FMT_SECOND: begin
                if (idx == 3'd0) op.kind = SEG_FLD1;
                op.fld = FLD_SEC;
            end
            FMT_YM: begin
                case (idx)
                    3'd0: op.kind = SEG_YEAR;
                    3'd1: op.kind = SEG_DASH;
                    3'd2: op.kind = SEG_FLD2;
                    default: op.kind = SEG_END;
                endcase
            end
            FMT_YYYYMMDD: begin
                case (idx)
                    3'd0: op.kind = SEG_YEAR;
                    3'd1: op.kind = SEG_FLD2;
                    3'd2: begin
                        op.kind = SEG_FLD2;
                        op.fld  = FLD_DAY;
                    end
                    default: op.kind = SEG_END;
                endcase
            end
            FMT_MMDDYYYY: begin
                case (idx)
                    3'd0: op.kind = SEG_FLD2;
                    3'd1: begin
                        op.kind = SEG_FLD2;
                        op.fld  = FLD_DAY;
                    end
                    3'd2: op.kind = SEG_YEAR;
                    default: op.kind = SEG_END;
                endcase
            end
            FMT_YMD: begin
                case (idx)
                    3'd0: op.kind = SEG_YEAR;
                    3'd1: op.kind = SEG_DASH;
                    3'd2: op.kind = SEG_FLD2;
                    3'd3: op.kind = SEG_DASH;
                    3'd4: begin
                        op.kind = SEG_FLD2;
                        op.fld  = FLD_DAY;
                    end
                    default: op.kind = SEG_END;
                endcase
            end
            default: op.kind = SEG_END;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

[src/dspe_front.sv]
`default_nettype none

module dspe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  logic           i_empty,
    input  logic           i_full,
    output logic           o_ready,
    output logic           o_push,
    output dspe_pkg::t_rec o_rec
);
    import dspe_pkg::*;

    localparam int LAY_14   = 0;
    localparam int LAY_DASH = 1;
    localparam int LAY_8    = 2;

    logic [4:0]  r_pos, n_pos;
    logic [2:0]  r_alive, n_alive;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_mon, n_mon, r_day, n_day, r_hour, n_hour;
    logic [6:0]  r_min, n_min, r_sec, n_sec;

    logic        dig;
    logic [3:0]  dv;
    logic        ok_dash;
    logic [17:0] year_acc;
    logic        match;
    logic        accept;
    logic        str_end;

    function automatic logic [6:0] acc2(input logic [6:0] f, input logic [3:0] d);
        logic [10:0] s;
        s = {4'b0, f} * 11'd10 + {7'b0, d};
        return s[6:0];
    endfunction

    always_comb begin
        dig = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        dv  = dig ? i_char[3:0] : 4'd0;

        n_alive = r_alive;
        if (!((r_pos < 5'd14) && dig)) n_alive[LAY_14] = 1'b0;
        if (!((r_pos < 5'd8) && dig))  n_alive[LAY_8]  = 1'b0;
        case (r_pos)
            5'd4, 5'd7:   ok_dash = (i_char == CH_DASH);
            5'd10:        ok_dash = (i_char == CH_SPACE) || (i_char inside {[CH_TAB:CH_CR]});
            5'd13, 5'd16: ok_dash = (i_char == CH_COLON);
            default:      ok_dash = (r_pos < 5'd19) && dig;
        endcase
        if (!ok_dash) n_alive[LAY_DASH] = 1'b0;

        year_acc = {4'b0, r_year} * 18'd10 + {14'b0, dv};
        n_year = r_year;
        n_mon  = r_mon;
        n_day  = r_day;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        if (dig) begin
            if (n_alive[LAY_14] || n_alive[LAY_8]) begin
                if (r_pos < 5'd4)       n_year = year_acc[13:0];
                else if (r_pos < 5'd6)  n_mon  = acc2(r_mon, dv);
                else if (r_pos < 5'd8)  n_day  = acc2(r_day, dv);
                else if (r_pos < 5'd10) n_hour = acc2(r_hour, dv);
                else if (r_pos < 5'd12) n_min  = acc2(r_min, dv);
                else if (r_pos < 5'd14) n_sec  = acc2(r_sec, dv);
            end else if (n_alive[LAY_DASH]) begin
                if (r_pos < 5'd4)                   n_year = year_acc[13:0];
                else if (r_pos inside {5'd5, 5'd6})   n_mon  = acc2(r_mon, dv);
                else if (r_pos inside {5'd8, 5'd9})   n_day  = acc2(r_day, dv);
                else if (r_pos inside {5'd11, 5'd12}) n_hour = acc2(r_hour, dv);
                else if (r_pos inside {5'd14, 5'd15}) n_min  = acc2(r_min, dv);
                else if (r_pos inside {5'd17, 5'd18}) n_sec  = acc2(r_sec, dv);
            end
        end

        // Saturate so an overlong string can never match
        n_pos = (r_pos == 5'd31) ? r_pos : r_pos + 5'd1;
        match = (n_alive[LAY_14] && (n_pos == 5'd14)) ||
                (n_alive[LAY_DASH] && (n_pos == 5'd19)) ||
                (n_alive[LAY_8] && (n_pos == 5'd8));

        o_ready = !i_full;
        accept  = i_valid && o_ready;
        str_end = i_empty || i_last;
        o_push  = accept && str_end;

        if (i_empty) begin
            o_rec = '0;
        end else begin
            o_rec.err  = !match;
            o_rec.year = n_year;
            o_rec.mon  = n_mon;
            o_rec.day  = n_day;
            o_rec.hour = n_hour;
            o_rec.mins = n_min;
            o_rec.secs = n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && str_end)) begin
            r_pos   <= '0;
            r_alive <= '1;
            r_year  <= '0;
            r_mon   <= '0;
            r_day   <= '0;
            r_hour  <= '0;
            r_min   <= '0;
            r_sec   <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_alive <= n_alive;
            r_year  <= n_year;
            r_mon   <= n_mon;
            r_day   <= n_day;
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
        end
    end

endmodule

`default_nettype wire

[src/dspe_fifo.sv]
`default_nettype none

module dspe_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dspe_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dspe_pkg::t_rec o_rec
);
    import dspe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("record pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("record popped from an empty queue");
`endif

endmodule

`default_nettype wire

[src/dspe_back.sv]
`default_nettype none

module dspe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dspe_pkg::t_cfg i_cfg,
    input  logic           i_q_empty,
    input  dspe_pkg::t_rec i_rec,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [7:0]     o_char,
    output logic           o_last,
    output logic           o_error,
    output logic           o_blank
);
    import dspe_pkg::*;

    t_bk_state   r_state, n_state;
    t_rec        r_rec;
    logic [6:0]  r_mon;
    logic [17:0] r_t;
    logic [31:0] r_prod;
    logic [15:0] r_yr;
    logic        r_neg;
    logic [14:0] r_mag;
    logic [3:0]  r_dig [5];
    logic [2:0]  r_ndig;
    logic [2:0]  r_seg, r_pos;

    logic        r_ovalid, r_olast, r_oerr, r_oempty;
    logic [7:0]  r_ochar;

    logic [15:0] sum_y;
    logic [17:0] t_calc;
    logic [13:0] q3;
    logic [17:0] rem3;
    logic [15:0] abs_y;
    logic [30:0] prod10;
    logic [11:0] q10;
    logic [14:0] rem10;

    t_seg_op     op, op_nx;
    logic [6:0]  fval;
    logic [3:0]  tens;
    logic [6:0]  ones7;
    logic [2:0]  seg_len;
    logic [2:0]  yidx;
    logic [7:0]  e_char;
    logic        seg_end, e_last, e_empty;
    logic        emit_go;

    // Offset and conversion datapath
    always_comb begin
        sum_y  = {2'b00, r_rec.year} + {i_cfg.amt[14], i_cfg.amt};
        t_calc = ({4'b0, r_rec.year} << 3) + ({4'b0, r_rec.year} << 2) + {11'b0, r_rec.mon}
               + {{3{i_cfg.amt[14]}}, i_cfg.amt} + DIV_BIAS;
        q3     = r_prod[30:17];
        rem3   = r_t - (({4'b0, q3} << 3) + ({4'b0, q3} << 2));
        abs_y  = r_yr[15] ? (~r_yr + 16'd1) : r_yr;
        prod10 = {16'b0, r_mag} * {15'b0, RECIP10};
        q10    = prod10[30:19];
        rem10  = r_mag - ({q10, 3'b000} + {2'b00, q10, 1'b0});
    end

    // Character selection for the current output step
    always_comb begin
        op    = dspe_seg_op(i_cfg.fmt, r_seg);
        op_nx = dspe_seg_op(i_cfg.fmt, r_seg + 3'd1);
        case (op.fld)
            FLD_MON:  fval = r_mon;
            FLD_DAY:  fval = r_rec.day;
            FLD_HOUR: fval = r_rec.hour;
            FLD_MIN:  fval = r_rec.mins;
            FLD_SEC:  fval = r_rec.secs;
            default:  fval = r_mon;
        endcase
        tens  = dspe_tens(fval);
        ones7 = fval - ({tens, 3'b000} + {2'b00, tens, 1'b0});
        yidx  = r_ndig - 3'd1 - (r_pos - {2'b00, r_neg});
        case (op.kind)
            SEG_YEAR: begin
                seg_len = r_ndig + {2'b00, r_neg};
                e_char  = (r_neg && (r_pos == 3'd0)) ? CH_DASH : (CH_ZERO | {4'b0, r_dig[yidx]});
            end
            SEG_DASH: begin
                seg_len = 3'd1;
                e_char  = CH_DASH;
            end
            SEG_FLD1: begin
                seg_len = (fval < 7'd10) ? 3'd1 : 3'd2;
                e_char  = ((seg_len == 3'd2) && (r_pos == 3'd0)) ? (CH_ZERO | {4'b0, tens})
                                                                : (CH_ZERO | {4'b0, ones7[3:0]});
            end
            SEG_FLD2: begin
                seg_len = 3'd2;
                e_char  = (r_pos == 3'd0) ? (CH_ZERO | {4'b0, tens})
                                          : (CH_ZERO | {4'b0, ones7[3:0]});
            end
            default: begin
                seg_len = 3'd1;
                e_char  = CH_NUL;
            end
        endcase
        seg_end = (r_pos == seg_len - 3'd1);
        e_empty = !r_rec.err && (op.kind == SEG_END);
        e_last  = r_rec.err || e_empty || (seg_end && (op_nx.kind == SEG_END));
    end

    // Sequencer outputs
    always_comb begin
        o_pop   = (r_state == BK_IDLE) && !i_q_empty;
        emit_go = (r_state == BK_EMIT) && (!r_ovalid || i_ready);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_q_empty) n_state = BK_OFFS;
            BK_OFFS: begin
                if (r_rec.err)                        n_state = BK_EMIT;
                else if (i_cfg.ofs_unit == OFS_MONTH) n_state = BK_DIV;
                else                                  n_state = BK_ABS;
            end
            BK_DIV:  n_state = BK_FIX;
            BK_FIX:  n_state = BK_ABS;
            BK_ABS:  n_state = BK_CONV;
            BK_CONV: if (q10 == 12'd0) n_state = BK_EMIT;
            BK_EMIT: if (emit_go && e_last) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                if (o_pop) r_rec <= i_rec;
            end
            BK_OFFS: begin
                r_mon <= r_rec.mon;
                r_t   <= t_calc;
                r_yr  <= (i_cfg.ofs_unit == OFS_YEAR) ? sum_y : {2'b00, r_rec.year};
                r_seg <= '0;
                r_pos <= '0;
            end
            BK_DIV: begin
                r_prod <= {16'b0, r_t[17:2]} * {16'b0, RECIP3};
            end
            BK_FIX: begin
                r_yr  <= {2'b00, q3} - Q_BIAS;
                r_mon <= {3'b000, rem3[3:0]} + 7'd1;
            end
            BK_ABS: begin
                r_neg  <= r_yr[15];
                r_mag  <= abs_y[14:0];
                r_ndig <= '0;
            end
            BK_CONV: begin
                r_dig[r_ndig] <= rem10[3:0];
                r_ndig        <= r_ndig + 3'd1;
                r_mag         <= {3'b000, q10};
            end
            BK_EMIT: begin
                if (emit_go) begin
                    if (seg_end) begin
                        r_seg <= r_seg + 3'd1;
                        r_pos <= '0;
                    end else begin
                        r_pos <= r_pos + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_ovalid <= 1'b0;
        else if (emit_go) r_ovalid <= 1'b1;
        else if (i_ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_ochar  <= (r_rec.err || e_empty) ? CH_NUL : e_char;
            r_olast  <= e_last;
            r_oerr   <= r_rec.err;
            r_oempty <= e_empty;
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;
    assign o_error = r_oerr;
    assign o_blank = r_oempty;

`ifndef NO_ASSERTIONS
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oerr) |-> (r_olast && !r_oempty))
        else $error("error result must be a single last result");
    a_empty_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oempty) |-> r_olast)
        else $error("empty result must be a single last result");
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BK_EMIT) && !r_rec.err) |-> ((r_ndig != 3'd0) && (r_ndig <= 3'd5)))
        else $error("year digit count out of range while emitting");
`endif

endmodule

`default_nettype wire

[src/date_string_part_extract_unit.sv]
`default_nettype none

// Date string part extractor. A date string streams in one character per
// request on the slave side, tlast on its final character; a request with
// tuser set stands for an empty string and ends any partial string. Strings of
// 14 digits, 8 digits (time zero) or "YYYY-MM-DD hh:mm:ss" with any whitespace
// between date and time are parsed; anything else yields one result with the
// error flag. After an optional year or month offset (months fold back into
// 1..12 by floor division) the part picked by format_code leaves as decimal
// ASCII, one request per character, tlast on the last; an unknown format gives
// one request with the empty flag. Rate: the front end takes one character
// per cycle while its record queue (QUEUE_DEPTH entries) has room. The back
// end sequencer handles one string at a time: an error goes straight to
// output, else it applies the offset (a month offset adds a divide and a fix
// step), takes the year's magnitude and converts one year digit (1 to 5) per
// step; a finished character waits in the output register while the next one
// is prepared. Configuration must be written only while idle; the block does not check.
module date_string_part_extract_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [14:0] i_cfg_wdata,
    // Character input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] date_char
    input  logic        i_s_axis_tlast,   // is_last_char
    input  logic        i_s_axis_tuser,   // [0] is_empty_string
    // Result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_char
    output logic        o_m_axis_tlast,   // out_last
    output logic [1:0]  o_m_axis_tuser    // [0] out_error, [1] out_empty
);
    import dspe_pkg::*;

    t_cfg r_cfg;
    t_rec push_rec, pop_rec;
    logic push, full, pop, q_empty;
    logic out_err, out_blank;

    // Hold configuration; writes beyond the register list drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FORMAT:   r_cfg.fmt      <= i_cfg_wdata[3:0];
                CFG_OFS_UNIT: r_cfg.ofs_unit <= i_cfg_wdata[1:0];
                CFG_OFS_AMT:  r_cfg.amt      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Parse characters and classify each finished string
    dspe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_char  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_empty (i_s_axis_tuser),
        .i_full  (full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    // Decouple parsing from formatting
    dspe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_rec   (pop_rec)
    );

    // Apply offset, convert and emit characters
    dspe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_rec     (pop_rec),
        .o_pop     (pop),
        .i_ready   (i_m_axis_tready),
        .o_valid   (o_m_axis_tvalid),
        .o_char    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .o_error   (out_err),
        .o_blank   (out_blank)
    );

    assign o_m_axis_tuser = {out_blank, out_err};

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

// Date string part extractor bench. The stimulus loop queues character
// requests per phase; each phase runs under one register setting (format
// code, offset unit, offset amount), written only while the block is idle.
// The driver feeds the slave side from the character backlog, the checker
// compares every result character with the predicted characters in order,
// and a watchdog ends the run when no request moves for too long.
module tb;
    import dspe_pkg::*;

    // Codes that the package leaves unnamed
    localparam logic [3:0] FMT_NONE  = 4'd10;
    localparam logic [3:0] FMT_LAST  = 4'd15;   // unknown code, acts like none
    localparam logic [1:0] OFS_NONE  = 2'd0;
    localparam logic [1:0] OFS_SPARE = 2'd3;    // unused unit, no offset

    localparam int NUM_PHASES     = 15;
    localparam int PRESSURE_PHASE = 3;
    localparam int PHASE_CHARS    = 22;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 24;
    localparam int QUIET_LIMIT    = 3000;
    localparam int MAX_TEXT       = 12;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       blank;
    } t_char_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       err;
        logic       blank;
    } t_out_char;

    typedef logic [7:0] t_text[$];

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [14:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = '0;
    logic        s_last    = 1'b0;
    logic        s_user    = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_data;
    logic        m_last;
    logic [1:0]  m_user;

    date_string_part_extract_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),     // [7:0] date_char
        .i_s_axis_tlast  (s_last),     // is_last_char
        .i_s_axis_tuser  (s_user),     // [0] is_empty_string
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),     // [7:0] out_char
        .o_m_axis_tlast  (m_last),     // out_last
        .o_m_axis_tuser  (m_user)      // [0] out_error, [1] out_empty
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow of the registers, updated as they are written
    logic [3:0]         fmt_reg  = '0;
    logic [1:0]         unit_reg = '0;
    logic signed [14:0] amt_reg  = '0;

    // Parse state of the string in progress
    logic [4:0]  char_pos;
    logic [2:0]  alive;        // bit0 14-digit, bit1 dashed, bit2 8-digit
    logic [13:0] year_acc;
    logic [6:0]  mon_acc;
    logic [6:0]  day_acc;
    logic [6:0]  hour_acc;
    logic [6:0]  min_acc;
    logic [6:0]  sec_acc;

    t_char_req char_backlog[$];
    t_out_char expected_chars[$];
    t_char_req offered;

    int queued_items   = 0;
    int chars_taken    = 0;
    int strings_taken  = 0;
    int results_seen   = 0;
    int error_results  = 0;
    int blank_results  = 0;
    int mismatches     = 0;
    int idle_odds      = 0;    // 0: no idling, else one chance in idle_odds
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_left      = 0;
    int hold_asks      = 0;
    int holds_done     = 0;
    int quiet_cycles   = 0;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic void clear_parse();
        char_pos = '0;
        alive    = 3'b111;
        year_acc = '0;
        mon_acc  = '0;
        day_acc  = '0;
        hour_acc = '0;
        min_acc  = '0;
        sec_acc  = '0;
    endfunction

    // Shift one decimal digit into a 7-bit part, wrapping like the block
    function automatic logic [6:0] shift_digit(input logic [6:0] f, input logic [3:0] d);
        return 7'(int'(f) * 10 + int'(d));
    endfunction

    function automatic string dec(input int v);
        return $sformatf("%0d", v);
    endfunction

    // Two-digit part: pad 0..9 with a leading zero
    function automatic string dec2(input int v);
        return (v >= 0 && v < 10) ? {"0", dec(v)} : dec(v);
    endfunction

    function automatic t_out_char out_char(input logic [7:0] ch, input logic last,
                                           input logic err, input logic blank);
        t_out_char c;
        c.ch    = ch;
        c.last  = last;
        c.err   = err;
        c.blank = blank;
        return c;
    endfunction

    // Apply the offset, format the chosen part and queue its characters
    function automatic void format_date_parts();
        int    yr;
        int    mo;
        int    tot;
        int    quo;
        int    rem;
        string txt;
        yr = year_acc;
        mo = mon_acc;
        case (unit_reg)
            OFS_YEAR: yr = yr + amt_reg;
            OFS_MONTH: begin
                // Floor division keeps the month in 1..12
                tot = yr * 12 + mo - 1 + amt_reg;
                quo = tot / 12;
                rem = tot % 12;
                if (rem < 0) begin
                    rem += 12;
                    quo -= 1;
                end
                yr = quo;
                mo = rem + 1;
            end
            default: ;
        endcase
        case (fmt_reg)
            FMT_YEAR:     txt = dec(yr);
            FMT_MONTH:    txt = dec(mo);
            FMT_DAY:      txt = dec(day_acc);
            FMT_HOUR:     txt = dec(hour_acc);
            FMT_MINUTE:   txt = dec(min_acc);
            FMT_SECOND:   txt = dec(sec_acc);
            FMT_YM:       txt = {dec(yr), "-", dec2(mo)};
            FMT_YYYYMMDD: txt = {dec(yr), dec2(mo), dec2(int'(day_acc))};
            FMT_MMDDYYYY: txt = {dec2(mo), dec2(int'(day_acc)), dec(yr)};
            FMT_YMD:      txt = {dec(yr), "-", dec2(mo), "-", dec2(int'(day_acc))};
            default:      txt = "";
        endcase
        if (txt.len() > MAX_TEXT)
            txt = txt.substr(0, MAX_TEXT - 1);
        if (txt.len() == 0) begin
            expected_chars.push_back(out_char(CH_NUL, 1'b1, 1'b0, 1'b1));
        end else begin
            for (int i = 0; i < txt.len(); i++)
                expected_chars.push_back(out_char(txt[i], i == txt.len() - 1, 1'b0, 1'b0));
        end
    endfunction

    // Advance the parse by one accepted character request
    function automatic void parse_char_request(input t_char_req r);
        logic       dig;
        logic       sep_ok;
        logic       hit;
        logic [3:0] dv;
        logic [4:0] p;
        logic [2:0] al;
        if (r.blank) begin
            // Empty string: drop any partial string, all parts zero
            clear_parse();
            format_date_parts();
            return;
        end
        dig = (r.ch >= CH_ZERO) && (r.ch <= CH_NINE);
        dv  = dig ? 4'(r.ch - CH_ZERO) : 4'd0;
        p   = char_pos;
        al  = alive;
        if (!(p < 14 && dig))
            al[0] = 1'b0;
        if (!(p < 8 && dig))
            al[2] = 1'b0;
        if (p == 4 || p == 7)
            sep_ok = (r.ch == CH_DASH);
        else if (p == 10)
            sep_ok = (r.ch == CH_SPACE) || (r.ch >= CH_TAB && r.ch <= CH_CR);
        else if (p == 13 || p == 16)
            sep_ok = (r.ch == CH_COLON);
        else
            sep_ok = (p < 19) && dig;
        if (!sep_ok)
            al[1] = 1'b0;

        if (dig && (al[0] || al[2])) begin
            if (p < 4)       year_acc = 14'(int'(year_acc) * 10 + int'(dv));
            else if (p < 6)  mon_acc  = shift_digit(mon_acc, dv);
            else if (p < 8)  day_acc  = shift_digit(day_acc, dv);
            else if (p < 10) hour_acc = shift_digit(hour_acc, dv);
            else if (p < 12) min_acc  = shift_digit(min_acc, dv);
            else if (p < 14) sec_acc  = shift_digit(sec_acc, dv);
        end else if (dig && al[1]) begin
            if (p < 4)                 year_acc = 14'(int'(year_acc) * 10 + int'(dv));
            else if (p == 5 || p == 6)   mon_acc  = shift_digit(mon_acc, dv);
            else if (p == 8 || p == 9)   day_acc  = shift_digit(day_acc, dv);
            else if (p == 11 || p == 12) hour_acc = shift_digit(hour_acc, dv);
            else if (p == 14 || p == 15) min_acc  = shift_digit(min_acc, dv);
            else if (p == 17 || p == 18) sec_acc  = shift_digit(sec_acc, dv);
        end

        // Position saturates, so an overlong string never matches
        if (p != 5'd31)
            p = p + 5'd1;
        char_pos = p;
        alive    = al;
        if (!r.last)
            return;

        hit = (al[0] && p == 14) || (al[1] && p == 19) || (al[2] && p == 8);
        if (!hit) begin
            clear_parse();
            expected_chars.push_back(out_char(CH_NUL, 1'b1, 1'b1, 1'b0));
            return;
        end
        format_date_parts();
        clear_parse();
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic void add_item(input logic [7:0] ch, input logic last,
                                     input logic blank);
        t_char_req r;
        r.ch    = ch;
        r.last  = last;
        r.blank = blank;
        char_backlog.push_back(r);
        queued_items++;
    endfunction

    function automatic t_text to_text(input string s);
        t_text t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    // Queue a text; mark its final character as last when asked
    function automatic void push_text(input t_text t, input logic ends);
        for (int i = 0; i < t.size(); i++)
            add_item(t[i], ends && (i == t.size() - 1), 1'b0);
    endfunction

    // Mostly plausible two-digit part, now and then anything 00..99
    function automatic int pick2(input int lo, input int hi);
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 99))
                                           : int'($urandom_range(lo, hi));
    endfunction

    // Well-formed text: 0 eight digits, 1 fourteen digits, else dashed form
    function automatic t_text date_text(input int layout);
        int         yv;
        logic [7:0] ws;
        string      s;
        if ($urandom_range(0, 7) == 0)
            yv = $urandom_range(0, 1) ? 9999 : 0;
        else
            yv = $urandom_range(0, 9999);
        ws = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
        case (layout)
            0: s = $sformatf("%04d%02d%02d", yv, pick2(1, 12), pick2(1, 31));
            1: s = $sformatf("%04d%02d%02d%02d%02d%02d", yv, pick2(1, 12), pick2(1, 31),
                             pick2(0, 23), pick2(0, 59), pick2(0, 59));
            default: s = $sformatf("%04d-%02d-%02d%c%02d:%02d:%02d", yv, pick2(1, 12),
                                   pick2(1, 31), ws, pick2(0, 23), pick2(0, 59),
                                   pick2(0, 59));
        endcase
        return to_text(s);
    endfunction

    // Queue one string: mostly well formed, the rest empty, cut off, broken or noise
    function automatic void add_one_string();
        t_text t;
        int    n;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            t = date_text(pick < 30 ? 0 : (pick < 50 ? 1 : 2));
            push_text(t, 1'b1);
        end else if (pick < 78) begin
            // empty string; its char and last flag must be ignored
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick < 84) begin
            // partial string dropped by an empty-string request
            t = date_text($urandom_range(0, 2));
            n = $urandom_range(1, t.size() - 1);
            t = t[0:n-1];
            push_text(t, 1'b0);
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick < 92) begin
            t = date_text($urandom_range(0, 2));
            case ($urandom_range(0, 2))
                0: begin
                    n = $urandom_range(0, t.size() - 1);
                    t[n] = 8'($urandom_range(0, 255));
                end
                1: begin
                    n = $urandom_range(1, t.size() - 1);
                    t = t[0:n-1];
                end
                default: begin
                    // overlong: keep appending digits past every layout
                    repeat ($urandom_range(1, 20))
                        t.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                end
            endcase
            push_text(t, 1'b1);
        end else begin
            n = $urandom_range(1, 35);
            repeat (n)
                t.push_back(8'($urandom_range(0, 255)));
            push_text(t, 1'b1);
        end
    endfunction

    // ---------------------------------------------------------------
    // Configuration writes, only while idle
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_FORMAT:   fmt_reg  = val[3:0];
            CFG_OFS_UNIT: unit_reg = val[1:0];
            default:      amt_reg  = val;
        endcase
    endtask

    task automatic set_config(input logic [3:0] fmt, input logic [1:0] unit, input int amt);
        write_reg(CFG_FORMAT, 15'(fmt));
        write_reg(CFG_OFS_UNIT, 15'(unit));
        write_reg(CFG_OFS_AMT, 15'(amt));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_amount();
        return int'($urandom_range(0, 19998)) - 9999;
    endfunction

    // Check at the falling edge so every update of the rising edge has landed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (char_backlog.size() != 0 || s_valid || expected_chars.size() != 0);
    endtask

    // ---------------------------------------------------------------
    // Driver: offer the backlog on the slave side, idling in bursts
    // ---------------------------------------------------------------
    always @(posedge clk) begin : drive_chars
        logic taken;
        taken = s_valid && s_ready;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (taken || !s_valid) begin
            // Predict as the request is taken
            if (taken) begin
                parse_char_request(offered);
                chars_taken++;
                if (offered.last || offered.blank)
                    strings_taken++;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                send_gap = $urandom_range(0, 16);
                s_valid <= 1'b0;
            end else if (char_backlog.size() > 0) begin
                offered = char_backlog.pop_front();
                s_valid <= 1'b1;
                s_data  <= offered.ch;
                s_last  <= offered.last;
                s_user  <= offered.blank;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Checker: compare each result with the oldest prediction
    // ---------------------------------------------------------------
    function automatic string show(input t_out_char c);
        return $sformatf("char=%02h last=%0b err=%0b empty=%0b", c.ch, c.last, c.err, c.blank);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] result mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk) begin : check_results
        t_out_char got;
        t_out_char want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = out_char(m_data, m_last, m_user[0], m_user[1]);
                results_seen++;
                if (got.err)
                    error_results++;
                if (got.blank)
                    blank_results++;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected %s", show(got)));
                end else begin
                    want = expected_chars.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf("got %s, want %s", show(got), show(want)));
                end
            end
            // Long hold-off on request, else random stall bursts
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_asks != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
                recv_gap = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: count cycles in which no request moves on either side
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // Phases: settle, write the registers, queue the phase's strings
    // ---------------------------------------------------------------
    initial begin : run_phases
        int target;
        clear_parse();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                // Hold off until the last result is out and the back end is quiet
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge clk);
                case (ph)
                    1:  set_config(FMT_YMD, OFS_NONE, 0);
                    2:  set_config(FMT_YYYYMMDD, OFS_YEAR, 9999);
                    3:  set_config(FMT_MMDDYYYY, OFS_YEAR, -9999);
                    4:  set_config(FMT_YM, OFS_MONTH, -9999);
                    5:  set_config(FMT_YMD, OFS_MONTH, 9999);
                    6:  set_config(FMT_MONTH, OFS_MONTH, rand_amount());
                    7:  set_config(FMT_DAY, OFS_SPARE, rand_amount());
                    8:  set_config(FMT_HOUR, OFS_NONE, rand_amount());
                    9:  set_config(FMT_MINUTE, OFS_YEAR, rand_amount());
                    10: set_config(FMT_SECOND, OFS_MONTH, rand_amount());
                    11: set_config(FMT_NONE, OFS_MONTH, rand_amount());
                    12: set_config(FMT_LAST, OFS_SPARE, rand_amount());
                    // year zero pushed below zero by a month offset
                    13: set_config(FMT_YEAR, OFS_MONTH, -9999);
                    default: set_config(4'($urandom_range(FMT_YEAR, FMT_NONE)),
                                        2'($urandom_range(OFS_NONE, OFS_SPARE)),
                                        rand_amount());
                endcase
            end

            @(negedge clk);
            // The last phase runs without any idling
            if (ph == NUM_PHASES - 1) begin
                idle_odds = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       idle_odds = 0;
                    1:       idle_odds = 3;
                    2:       idle_odds = 6;
                    default: idle_odds = 12;
                endcase
            end

            if (ph == 0) begin
                // Directed strings under the reset setting (year, no offset)
                add_item(8'hFF, 1'b1, 1'b1);             // empty string, flags ignored
                push_text(to_text("99991231"), 1'b1);    // eight digits, top year
                push_text(to_text("12"), 1'b0);          // partial string ...
                add_item(CH_NUL, 1'b0, 1'b1);            // ... dropped by an empty one
                add_item(8'h80, 1'b1, 1'b0);             // lone non-digit: no layout
                push_text(to_text("00000000"), 1'b1);    // year zero
            end else begin
                target = queued_items + PHASE_CHARS;
                if (ph == PRESSURE_PHASE) begin
                    // Stall the output while a burst of empty strings fills the queue
                    hold_asks++;
                    repeat (12)
                        add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                end
                while (queued_items < target)
                    add_one_string();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d characters in %0d strings over %0d register settings,",
                 chars_taken, strings_taken, NUM_PHASES);
        $display("checking %0d result characters (%0d no-layout, %0d empty-format).",
                 results_seen, error_results, blank_results);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
src/dspe_pkg.sv
src/dspe_front.sv
src/dspe_fifo.sv
src/dspe_back.sv
src/date_string_part_extract_unit.sv
tb/sv/tb.sv
